@@ hw/rtl/mxt_pkg.sv @@
// ----------------------------------------------------------------------------
// mxt_pkg
// shared types and codes for the maximum-xor binary trie
// ----------------------------------------------------------------------------
package mxt_pkg;

    localparam int FIELD_W = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_WALK,
        S_PUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    clear;
        logic    begin_walk;
        logic    step;
        logic    set_code;
        t_status code;
        logic    push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             last;
        logic             dead;
        logic             slot_free;
    } t_stat;

endpackage

@@ hw/rtl/mxt_if.sv @@
// ----------------------------------------------------------------------------
// mxt_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mxt_req_if;
    logic                            valid;
    logic                            ready;
    logic [mxt_pkg::REQ_W-1:0]       req_type;
    logic [mxt_pkg::FIELD_W-1:0]     key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface mxt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [mxt_pkg::FIELD_W-1:0]     best_match;
    logic [mxt_pkg::STAT_W-1:0]      status;

    modport source (output valid, output best_match, output status, input ready);
    modport sink   (input valid, input best_match, input status, output ready);
endinterface

@@ hw/rtl/max_xor_binary_trie.sv @@
// ----------------------------------------------------------------------------
// max_xor_binary_trie
// binary trie of keys with insert, clear and maximum-xor partner query
// insert and query walk the trie one step per key bit, then respond
// one word at a time; the response push waits for a free output slot
// clear, refused insert and empty query skip the walk and respond directly
// reset: the root entry is written in the init state before the first word is taken
// ----------------------------------------------------------------------------
module max_xor_binary_trie #(
    parameter int NODE_COUNT = 65536,
    parameter int KEY_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mxt_req_if.sink    i_req,
    mxt_rsp_if.source  o_rsp
);

    mxt_pkg::t_cmd  cmd;
    mxt_pkg::t_stat stat;

    mxt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mxt_dp #(
        .NODE_COUNT (NODE_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

@@ hw/rtl/mxt_ram.sv @@
// ----------------------------------------------------------------------------
// mxt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mxt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/mxt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mxt_ctrl
// sequencer for clear, insert and query walks
// ----------------------------------------------------------------------------
module mxt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mxt_pkg::t_stat i_stat,
    output mxt_pkg::t_cmd  o_cmd
);

    mxt_pkg::t_state r_state;
    mxt_pkg::t_state n_state;
    logic            walk_go;

    // decide at start whether the request needs a trie walk
    always_comb begin
        walk_go = 1'b0;
        unique case (mxt_pkg::t_req'(i_stat.req))
            mxt_pkg::REQ_INSERT: walk_go = !i_stat.full;
            mxt_pkg::REQ_QUERY:  walk_go = !i_stat.empty;
            default:             walk_go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mxt_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mxt_pkg::S_INIT: n_state = mxt_pkg::S_IDLE;
            mxt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = mxt_pkg::S_START;
            end
            mxt_pkg::S_START: n_state = walk_go ? mxt_pkg::S_WALK : mxt_pkg::S_PUSH;
            mxt_pkg::S_WALK: begin
                if (i_stat.last || i_stat.dead) n_state = mxt_pkg::S_PUSH;
            end
            mxt_pkg::S_PUSH: begin
                if (i_stat.slot_free) n_state = mxt_pkg::S_IDLE;
            end
            default: n_state = mxt_pkg::S_INIT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = mxt_pkg::ST_OK;
        o_in_ready = 1'b0;
        unique case (r_state)
            mxt_pkg::S_INIT: o_cmd.clear = 1'b1;
            mxt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mxt_pkg::S_START: begin
                o_cmd.begin_walk = walk_go;
                o_cmd.set_code   = !walk_go;
                unique case (mxt_pkg::t_req'(i_stat.req))
                    mxt_pkg::REQ_CLEAR:  o_cmd.clear = 1'b1;
                    mxt_pkg::REQ_INSERT: o_cmd.code  = mxt_pkg::ST_FULL;
                    mxt_pkg::REQ_QUERY:  o_cmd.code  = mxt_pkg::ST_EMPTY;
                    default:             o_cmd.code  = mxt_pkg::ST_OK;
                endcase
                if (mxt_pkg::t_req'(i_stat.req) == mxt_pkg::REQ_CLEAR) begin
                    o_cmd.code = mxt_pkg::ST_OK;
                end
            end
            mxt_pkg::S_WALK: begin
                o_cmd.step     = 1'b1;
                o_cmd.set_code = i_stat.last || i_stat.dead;
                o_cmd.code     = mxt_pkg::ST_OK;
            end
            mxt_pkg::S_PUSH: o_cmd.push = i_stat.slot_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/mxt_dp.sv @@
// ----------------------------------------------------------------------------
// mxt_dp
// node store, walk registers and response register of the trie
// ----------------------------------------------------------------------------
module mxt_dp #(
    parameter int NODE_COUNT = 65536,
    parameter int KEY_BITS   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mxt_pkg::t_cmd    i_cmd,
    output mxt_pkg::t_stat   o_stat,
    mxt_req_if.sink          i_req,
    mxt_rsp_if.source        o_rsp
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int UW = NW + 1;
    localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam logic [UW-1:0] FULL_LIM = UW'(NODE_COUNT - KEY_BITS);

    logic [NW-1:0]       r_node;
    logic [UW-1:0]       r_used;
    logic [LW-1:0]       r_level;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_acc;
    logic                r_fresh;
    logic [1:0]          r_req;
    mxt_pkg::t_status    r_code;

    logic                r_out_valid;
    logic [KEY_BITS-1:0] r_out_best;
    mxt_pkg::t_status    r_out_status;

    logic                we;
    logic [NW-1:0]       wr_addr;
    logic [2*NW-1:0]     wr_data;
    logic [NW-1:0]       rd_addr;
    logic [2*NW-1:0]     rd_data;
    logic [2*NW-1:0]     base;

    logic                cur_bit;
    logic [NW-1:0]       link_same;
    logic [NW-1:0]       link_opp;
    logic [NW-1:0]       new_link;
    logic                is_ins;
    logic                ins_hit;

    mxt_ram #(
        .WIDTH (2 * NW),
        .DEPTH (NODE_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cur_bit   = r_key[r_level];
    assign link_same = cur_bit ? rd_data[2*NW-1:NW] : rd_data[NW-1:0];
    assign link_opp  = cur_bit ? rd_data[NW-1:0] : rd_data[2*NW-1:NW];
    assign new_link  = r_used[NW-1:0];
    assign is_ins    = (r_req == mxt_pkg::REQ_INSERT);
    assign ins_hit   = !r_fresh && (link_same != '0);
    assign base      = r_fresh ? '0 : rd_data;

    // store port selection
    always_comb begin
        we      = 1'b0;
        wr_addr = r_node;
        wr_data = '0;
        rd_addr = '0;
        if (i_cmd.clear) begin
            we      = 1'b1;
            wr_addr = '0;
        end else if (i_cmd.step) begin
            if (is_ins) begin
                if (ins_hit) begin
                    rd_addr = link_same;
                end else begin
                    we      = 1'b1;
                    wr_data = cur_bit ? {new_link, base[NW-1:0]}
                                      : {base[2*NW-1:NW], new_link};
                end
            end else begin
                rd_addr = (link_opp != '0) ? link_opp : link_same;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= UW'(1);
            r_fresh <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_req <= i_req.req_type;
                r_key <= i_req.key[KEY_BITS-1:0];
                r_acc <= '0;
            end
            if (i_cmd.clear) begin
                r_used <= UW'(1);
            end
            if (i_cmd.begin_walk) begin
                r_node  <= '0;
                r_level <= LW'(KEY_BITS - 1);
                r_fresh <= 1'b0;
            end
            if (i_cmd.step) begin
                r_level <= r_level - LW'(1);
                if (is_ins) begin
                    if (ins_hit) begin
                        r_node <= link_same;
                    end else begin
                        r_node  <= new_link;
                        r_used  <= r_used + UW'(1);
                        r_fresh <= 1'b1;
                    end
                end else if (link_opp != '0) begin
                    r_node         <= link_opp;
                    r_acc[r_level] <= ~cur_bit;
                end else if (link_same != '0) begin
                    r_node         <= link_same;
                    r_acc[r_level] <= cur_bit;
                end
            end
            if (i_cmd.set_code) begin
                r_code <= i_cmd.code;
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_out_valid  <= 1'b1;
                r_out_best   <= r_acc;
                r_out_status <= r_code;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.best_match = mxt_pkg::FIELD_W'(r_out_best);
    assign o_rsp.status     = r_out_status;

    assign o_stat.req       = r_req;
    assign o_stat.full      = (r_used > FULL_LIM);
    assign o_stat.empty     = (r_used <= UW'(1));
    assign o_stat.last      = (r_level == '0);
    assign o_stat.dead      = !is_ins && (link_opp == '0) && (link_same == '0);
    assign o_stat.slot_free = !r_out_valid || o_rsp.ready;

endmodule
